[rtl/ffra_pkg.sv]
package ffra_pkg;

   localparam int DEF_SLOTS = 1024;
   localparam int FIELD_W   = 11;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_WRITE
   } state_type;

endpackage

[rtl/ffra_ram.sv]
module ffra_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/first_fit_run_allocator.sv]
// First-fit run allocator over slots 1..SLOTS, one occupancy bit per slot held in a
// single-port-write, registered-read RAM. After reset the block clears every RAM slot
// with busy high. An allocate scans the slots in order at one slot per cycle through
// the RAM read port to find the lowest fitting run, then writes each granted slot
// occupied; the result beat (start slot, or 0 when nothing fits) is strobed once on
// rsp_strobe as soon as the search ends, and the receiver cannot hold it off. A
// zero-length allocate answers 0 without a scan. A free writes one slot per cycle over
// the clipped range. A new request is taken only while busy is low.
module first_fit_run_allocator #(
   parameter int SLOTS = ffra_pkg::DEF_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_opcode,
   input  logic [ffra_pkg::FIELD_W-1:0]   req_start_slot,
   input  logic [ffra_pkg::FIELD_W-1:0]   req_run_length,
   output logic                           rsp_strobe,
   output logic [ffra_pkg::FIELD_W-1:0]   rsp_granted_start
);
   import ffra_pkg::*;

   localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW  = $clog2(SLOTS + 1);
   localparam int CW  = ((PW > FIELD_W) ? PW : FIELD_W) + 1;
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   state_type         state_ff, state_in;
   logic [CW-1:0]     iss_ff, iss_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     pend_pos_ff, pend_pos_in;
   logic [CW-1:0]     run_ff, run_in;
   logic [CW-1:0]     run_start_ff, run_start_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [CW-1:0]     wr_pos_ff, wr_pos_in;
   logic [CW-1:0]     wr_end_ff, wr_end_in;
   logic              wr_val_ff, wr_val_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [FIELD_W-1:0] rsp_start_ff, rsp_start_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic              ram_wr_data;
   logic              ram_rd_data;

   logic              accept;
   logic [CW-1:0]     req_s, req_len, free_lo, free_hi;
   logic [CW-1:0]     new_run, new_start;

   ffra_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (iss_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      req_s   = CW'(req_start_slot);
      req_len = CW'(req_run_length);
      free_lo = (req_s == '0) ? ONE_C : req_s;
      free_hi = req_s + req_len - ONE_C;
      if (free_hi > SLOTS_C) begin
         free_hi = SLOTS_C;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= 1'b0;
         wr_pos_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_ff       <= pend_in;
         wr_pos_ff     <= wr_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff       <= iss_in;
      pend_pos_ff  <= pend_pos_in;
      run_ff       <= run_in;
      run_start_ff <= run_start_in;
      len_ff       <= len_in;
      wr_end_ff    <= wr_end_in;
      wr_val_ff    <= wr_val_in;
      rsp_start_ff <= rsp_start_in;
   end

   always_comb begin
      state_in      = state_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      pend_pos_in   = pend_pos_ff;
      run_in        = run_ff;
      run_start_in  = run_start_ff;
      len_in        = len_ff;
      wr_pos_in     = wr_pos_ff;
      wr_end_in     = wr_end_ff;
      wr_val_in     = wr_val_ff;
      rsp_strobe_in = 1'b0;
      rsp_start_in  = rsp_start_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wr_pos_ff[AW-1:0];
      ram_wr_data   = wr_val_ff;
      new_run       = ram_rd_data ? '0 : run_ff + ONE_C;
      new_start     = (run_ff == '0) ? pend_pos_ff : run_start_ff;

      case (state_ff)
         S_CLEAR: begin
            // wr_pos counts 0-based here
            ram_wr_en   = 1'b1;
            ram_wr_data = 1'b0;
            if (wr_pos_ff == SLOTS_C - ONE_C) begin
               state_in  = S_IDLE;
               wr_pos_in = '0;
            end else begin
               wr_pos_in = wr_pos_ff + ONE_C;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_ALLOC) begin
                  if (req_len == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_start_in  = '0;
                  end else begin
                     state_in = S_SCAN;
                     iss_in   = '0;
                     run_in   = '0;
                     len_in   = req_len;
                  end
               end else if (req_len != '0 && free_lo <= free_hi && free_lo <= SLOTS_C) begin
                  state_in  = S_WRITE;
                  wr_pos_in = free_lo;
                  wr_end_in = free_hi;
                  wr_val_in = 1'b0;
               end
            end
         end
         S_SCAN: begin
            if (iss_ff < SLOTS_C) begin
               pend_in     = 1'b1;
               pend_pos_in = iss_ff + ONE_C;
               iss_in      = iss_ff + ONE_C;
            end
            if (pend_ff) begin
               run_in       = new_run;
               run_start_in = new_start;
               // occupied bit is 1, a free slot extends the current run
               if (!ram_rd_data && new_run == len_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_start_in  = new_start[FIELD_W-1:0];
                  state_in      = S_WRITE;
                  pend_in       = 1'b0;
                  wr_pos_in     = new_start;
                  wr_end_in     = new_start + len_ff - ONE_C;
                  wr_val_in     = 1'b1;
               end else if (pend_pos_ff == SLOTS_C) begin
                  rsp_strobe_in = 1'b1;
                  rsp_start_in  = '0;
                  state_in      = S_IDLE;
                  pend_in       = 1'b0;
               end
            end
         end
         S_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(wr_pos_ff - ONE_C);
            if (wr_pos_ff == wr_end_ff) begin
               state_in = S_IDLE;
            end else begin
               wr_pos_in = wr_pos_ff + ONE_C;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_granted_start = rsp_start_ff;

   a_grant_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_granted_start != '0) |-> (state_ff == S_WRITE))
      else $error("granted run not being marked");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (wr_pos_ff <= wr_end_ff && wr_pos_ff != '0))
      else $error("write position outside range");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_strobe)
      else $error("result beat during clearing pass");

   a_scan_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && pend_ff && pend_pos_ff == SLOTS_C) |=> (state_ff != S_SCAN))
      else $error("scan ran past last slot");

endmodule
